// ===== hdl/iou_pkg.sv =====
// iou_pkg: shared types for the box intersection-over-union pipeline
// no dependencies; imported by iou_geom, iou_div and the top level
`default_nettype none

package iou_pkg;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic empty;
  } iou_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/iou_ifs.sv =====
// iou_ifs: valid/ready channel interfaces for box pairs in and ratios out
// depends on nothing beyond the parameters passed in by the top level
`default_nettype none

interface iou_box_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] a_left;
  logic [COORD_BITS-1:0] a_top;
  logic [COORD_BITS-1:0] a_width;
  logic [COORD_BITS-1:0] a_height;
  logic [COORD_BITS-1:0] b_left;
  logic [COORD_BITS-1:0] b_top;
  logic [COORD_BITS-1:0] b_width;
  logic [COORD_BITS-1:0] b_height;

  modport source (
    output valid, a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height,
    input  ready
  );
  modport sink (
    input  valid, a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height,
    output ready
  );
endinterface

interface iou_ratio_if #(
  parameter int FRAC_BITS = 16
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] ratio;
  logic               union_empty;

  modport source (
    output valid, ratio, union_empty,
    input  ready
  );
  modport sink (
    input  valid, ratio, union_empty,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/iou_geom.sv =====
// iou_geom: three pipeline stages: overlaps, area products, union area
// depends on iou_pkg
`default_nettype none

module iou_geom #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [COORD_BITS-1:0]     a_left,
  input  wire logic [COORD_BITS-1:0]     a_top,
  input  wire logic [COORD_BITS-1:0]     a_width,
  input  wire logic [COORD_BITS-1:0]     a_height,
  input  wire logic [COORD_BITS-1:0]     b_left,
  input  wire logic [COORD_BITS-1:0]     b_top,
  input  wire logic [COORD_BITS-1:0]     b_width,
  input  wire logic [COORD_BITS-1:0]     b_height,
  output iou_pkg::iou_ctrl_t             ctrl,
  output logic [2*COORD_BITS-1:0]        inter,
  output logic [2*COORD_BITS:0]          uni
);
  import iou_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int AW = 2 * COORD_BITS;
  localparam int UW = AW + 1;

  logic [CW:0]   ax_hi, bx_hi, ay_hi, by_hi;
  logic [CW-1:0] lo_x, lo_y;
  logic [CW:0]   hi_x, hi_y, ov_x_full, ov_y_full;

  logic          s1_valid_r;
  logic [CW-1:0] ov_x_r, ov_y_r, aw_r, ah_r, bw_r, bh_r;

  logic          s2_valid_r;
  logic [AW-1:0] inter2_r, area_a_r, area_b_r;

  logic [UW-1:0] uni_nxt;
  iou_ctrl_t     ctrl_r;
  logic [AW-1:0] inter_r;
  logic [UW-1:0] uni_r;

  // overlap on each axis, zero when disjoint
  always_comb begin
    ax_hi = {1'b0, a_left} + {1'b0, a_width};
    bx_hi = {1'b0, b_left} + {1'b0, b_width};
    ay_hi = {1'b0, a_top} + {1'b0, a_height};
    by_hi = {1'b0, b_top} + {1'b0, b_height};
    lo_x  = (a_left > b_left) ? a_left : b_left;
    lo_y  = (a_top > b_top) ? a_top : b_top;
    hi_x  = (ax_hi < bx_hi) ? ax_hi : bx_hi;
    hi_y  = (ay_hi < by_hi) ? ay_hi : by_hi;
    ov_x_full = (hi_x > {1'b0, lo_x}) ? hi_x - {1'b0, lo_x} : '0;
    ov_y_full = (hi_y > {1'b0, lo_y}) ? hi_y - {1'b0, lo_y} : '0;
  end

  assign uni_nxt = {1'b0, area_a_r} + {1'b0, area_b_r} - {1'b0, inter2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      ctrl_r.valid <= 1'b0;
    end else if (en) begin
      s1_valid_r   <= in_valid;
      s2_valid_r   <= s1_valid_r;
      ctrl_r.valid <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ov_x_r       <= ov_x_full[CW-1:0];
      ov_y_r       <= ov_y_full[CW-1:0];
      aw_r         <= a_width;
      ah_r         <= a_height;
      bw_r         <= b_width;
      bh_r         <= b_height;
      inter2_r     <= {{CW{1'b0}}, ov_x_r} * {{CW{1'b0}}, ov_y_r};
      area_a_r     <= {{CW{1'b0}}, aw_r} * {{CW{1'b0}}, ah_r};
      area_b_r     <= {{CW{1'b0}}, bw_r} * {{CW{1'b0}}, bh_r};
      inter_r      <= inter2_r;
      uni_r        <= uni_nxt;
      ctrl_r.empty <= (uni_nxt == '0);
    end
  end

  assign ctrl  = ctrl_r;
  assign inter = inter_r;
  assign uni   = uni_r;

endmodule

`default_nettype wire

// ===== hdl/iou_div.sv =====
// iou_div: restoring divider, one quotient bit per pipeline stage, plus output register
// depends on iou_pkg
`default_nettype none

module iou_div #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire iou_pkg::iou_ctrl_t    ctrl_in,
  input  wire logic [2*COORD_BITS-1:0] inter,
  input  wire logic [2*COORD_BITS:0]   uni,
  output iou_pkg::iou_ctrl_t         ctrl_out,
  output logic [FRAC_BITS:0]         ratio
);
  import iou_pkg::*;

  localparam int RW = 2 * COORD_BITS + 1;
  localparam int TW = RW + 1;
  localparam int NS = FRAC_BITS + 1;

  logic [TW-1:0]      trial   [0:NS-1];
  logic [RW-1:0]      uni_cur [0:NS-1];
  logic [TW-1:0]      diff    [0:NS-1];
  logic [NS-1:0]      ge;
  logic [RW-1:0]      rem_nxt [0:NS-2];
  logic [FRAC_BITS:0] q_nxt   [0:NS-1];
  iou_ctrl_t          ctrl_nxt [0:NS-1];

  logic [RW-1:0]      rem_r   [0:NS-2];
  logic [RW-1:0]      uni_r   [0:NS-2];
  logic [FRAC_BITS:0] q_r     [0:NS-1];
  iou_ctrl_t          ctrl_r  [0:NS-1];

  iou_ctrl_t          out_ctrl_r;
  logic [FRAC_BITS:0] ratio_r;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        trial[k]    = {1'b0, 1'b0, inter};
        uni_cur[k]  = uni;
        ctrl_nxt[k] = ctrl_in;
      end else begin
        trial[k]    = {rem_r[k-1], 1'b0};
        uni_cur[k]  = uni_r[k-1];
        ctrl_nxt[k] = ctrl_r[k-1];
      end
      diff[k] = trial[k] - {1'b0, uni_cur[k]};
      ge[k]   = (trial[k] >= {1'b0, uni_cur[k]});
      if (k == 0) begin
        q_nxt[k] = {{FRAC_BITS{1'b0}}, ge[k]};
      end else begin
        q_nxt[k] = {q_r[k-1][FRAC_BITS-1:0], ge[k]};
      end
      if (k < NS - 1) begin
        rem_nxt[k] = ge[k] ? diff[k][RW-1:0] : trial[k][RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        ctrl_r[k].valid <= 1'b0;
      end
      out_ctrl_r.valid <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NS; k++) begin
        ctrl_r[k] <= ctrl_nxt[k];
        q_r[k]    <= q_nxt[k];
      end
      for (int k = 0; k < NS - 1; k++) begin
        rem_r[k] <= rem_nxt[k];
        uni_r[k] <= uni_cur[k];
      end
      out_ctrl_r <= ctrl_r[NS-1];
      ratio_r    <= ctrl_r[NS-1].empty ? '0 : q_r[NS-1];
    end
  end

  assign ctrl_out = out_ctrl_r;
  assign ratio    = ratio_r;

endmodule

`default_nettype wire

// ===== hdl/box_intersection_over_union.sv =====
// box_intersection_over_union: top level of the box IoU pipeline
// depends on iou_pkg, iou_ifs, iou_geom and iou_div
//
// usage:
//   in_box carries one item per handshake: two boxes, each as left, top,
//   width and height. out_iou returns one item per input item, in order:
//   ratio = floor(intersection * 2^FRAC_BITS / union), so 2^FRAC_BITS is 1.0,
//   and union_empty, set when both boxes have zero area (ratio is then 0).
//   the pipeline has three stages for overlap, area products and union,
//   one restoring-divider stage per quotient bit, then the output register.
//   throughput is one item per cycle while out_iou does not stall; the
//   whole pipeline advances together.
//   when out_iou stalls with a result held, the pipeline freezes and
//   in_box.ready drops in the same cycle; nothing is lost or repeated.
//   synchronous active-low reset empties the pipeline; no other state exists.
`default_nettype none

module box_intersection_over_union #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  iou_box_if.sink      in_box,
  iou_ratio_if.source  out_iou
);
  import iou_pkg::*;

  logic                  en;
  iou_ctrl_t             geom_ctrl;
  logic [2*COORD_BITS-1:0] geom_inter;
  logic [2*COORD_BITS:0]   geom_uni;
  iou_ctrl_t             div_ctrl;
  logic [FRAC_BITS:0]    div_ratio;

  assign en           = !div_ctrl.valid || out_iou.ready;
  assign in_box.ready = en;

  iou_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_box.valid),
    .a_left   (in_box.a_left),
    .a_top    (in_box.a_top),
    .a_width  (in_box.a_width),
    .a_height (in_box.a_height),
    .b_left   (in_box.b_left),
    .b_top    (in_box.b_top),
    .b_width  (in_box.b_width),
    .b_height (in_box.b_height),
    .ctrl     (geom_ctrl),
    .inter    (geom_inter),
    .uni      (geom_uni)
  );

  iou_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctrl_in  (geom_ctrl),
    .inter    (geom_inter),
    .uni      (geom_uni),
    .ctrl_out (div_ctrl),
    .ratio    (div_ratio)
  );

  assign out_iou.valid       = div_ctrl.valid;
  assign out_iou.ratio       = div_ratio;
  assign out_iou.union_empty = div_ctrl.empty;

endmodule

`default_nettype wire

// ===== tb/sv/box_intersection_over_union_test.sv =====
// box_intersection_over_union_test: self-checking bench for the box iou pipeline
// drives box pairs through iou_box_if, checks ratios on iou_ratio_if against a local predictor
// depends on iou_ifs and box_intersection_over_union
`default_nettype none

module box_intersection_over_union_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int LATENCY    = FRAC_BITS + 5;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t a_left;
    coord_t a_top;
    coord_t a_width;
    coord_t a_height;
    coord_t b_left;
    coord_t b_top;
    coord_t b_width;
    coord_t b_height;
  } box_pair_t;

  typedef struct packed {
    logic [FRAC_BITS:0] ratio;
    logic               union_empty;
  } iou_t;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_OVERLAP,
    SHAPE_ZERO_AREA,
    SHAPE_NESTED,
    SHAPE_TOUCHING,
    SHAPE_FAR_EDGE
  } box_shape_e;

  logic clk;
  logic rst_n;

  iou_box_if   #(.COORD_BITS(COORD_BITS)) box_ch ();
  iou_ratio_if #(.FRAC_BITS(FRAC_BITS))   iou_ch ();

  box_intersection_over_union #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_box (box_ch.sink),
    .out_iou(iou_ch.source)
  );

  iou_t pending_ious[$];
  int   mismatches  = 0;
  bit   src_idles   = 1'b0;
  bit   sink_idles  = 1'b0;
  int   hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint unsigned overlap_len(coord_t lo1, coord_t len1,
                                                  coord_t lo2, coord_t len2);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned hi1;
    longint unsigned hi2;
    lo  = (lo1 > lo2) ? lo1 : lo2;
    hi1 = longint'(lo1) + longint'(len1);
    hi2 = longint'(lo2) + longint'(len2);
    hi  = (hi1 < hi2) ? hi1 : hi2;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic iou_t predict_iou(box_pair_t b);
    longint unsigned inter;
    longint unsigned area_sum;
    longint unsigned uni;
    iou_t            r;
    inter = overlap_len(b.a_left, b.a_width, b.b_left, b.b_width) *
            overlap_len(b.a_top, b.a_height, b.b_top, b.b_height);
    area_sum = longint'(b.a_width) * longint'(b.a_height) +
               longint'(b.b_width) * longint'(b.b_height);
    uni = area_sum - inter;
    if (uni == 0) begin
      r.ratio       = '0;
      r.union_empty = 1'b1;
    end else begin
      r.ratio       = (FRAC_BITS+1)'((inter << FRAC_BITS) / uni);
      r.union_empty = 1'b0;
    end
    return r;
  endfunction

  function automatic box_pair_t boxes(int ax, int ay, int aw, int ah,
                                      int bx, int by, int bw, int bh);
    box_pair_t b;
    b.a_left   = coord_t'(ax);
    b.a_top    = coord_t'(ay);
    b.a_width  = coord_t'(aw);
    b.a_height = coord_t'(ah);
    b.b_left   = coord_t'(bx);
    b.b_top    = coord_t'(by);
    b.b_width  = coord_t'(bw);
    b.b_height = coord_t'(bh);
    return b;
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_t_max();
    return coord_t'(v);
  endfunction

  function automatic coord_t COORD_t_max();
    return '1;
  endfunction

  function automatic int small_extent();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, COORD_MAX));
    return int'($urandom_range(1, 255));
  endfunction

  function automatic box_pair_t random_boxes(box_shape_e shape);
    box_pair_t b;
    int        ax, ay, aw, ah;
    ax = int'($urandom_range(0, COORD_MAX));
    ay = int'($urandom_range(0, COORD_MAX));
    aw = small_extent();
    ah = small_extent();
    b  = boxes(ax, ay, aw, ah, 0, 0, 0, 0);
    case (shape)
      SHAPE_NOISE: begin
        b = {$urandom(), $urandom(), $urandom()};
      end
      SHAPE_OVERLAP: begin
        b.b_left   = clamp_coord(ax + $urandom_range(0, aw) - $urandom_range(0, aw));
        b.b_top    = clamp_coord(ay + $urandom_range(0, ah) - $urandom_range(0, ah));
        b.b_width  = coord_t'(small_extent());
        b.b_height = coord_t'(small_extent());
      end
      SHAPE_ZERO_AREA: begin
        b.b_left   = clamp_coord(ax + $urandom_range(0, aw));
        b.b_top    = clamp_coord(ay + $urandom_range(0, ah));
        b.b_width  = coord_t'(small_extent());
        b.b_height = coord_t'(small_extent());
        case ($urandom_range(0, 3))
          0: b.a_width  = '0;
          1: b.a_height = '0;
          2: b.b_width  = '0;
          default: begin
            b.a_width  = '0;
            b.b_height = '0;
          end
        endcase
      end
      SHAPE_NESTED: begin
        b.b_left   = clamp_coord(ax + $urandom_range(0, aw));
        b.b_top    = clamp_coord(ay + $urandom_range(0, ah));
        b.b_width  = coord_t'($urandom_range(0, aw));
        b.b_height = coord_t'($urandom_range(0, ah));
        if ($urandom_range(0, 1) == 1) b = {b[47:0], b[95:48]};
      end
      SHAPE_TOUCHING: begin
        b.b_width  = coord_t'(small_extent());
        b.b_height = coord_t'(small_extent());
        b.b_left   = ($urandom_range(0, 1) == 1) ? clamp_coord(ax + aw) : b.a_left;
        b.b_top    = ($urandom_range(0, 1) == 1) ? clamp_coord(ay + ah) : b.a_top;
        if ($urandom_range(0, 1) == 1) b = {b[47:0], b[95:48]};
      end
      default: begin
        b.a_left   = coord_t'($urandom_range(COORD_MAX - 300, COORD_MAX));
        b.a_top    = coord_t'($urandom_range(COORD_MAX - 300, COORD_MAX));
        b.a_width  = coord_t'($urandom_range(COORD_MAX - 300, COORD_MAX));
        b.a_height = coord_t'($urandom_range(0, COORD_MAX));
        b.b_left   = coord_t'($urandom_range(COORD_MAX - 300, COORD_MAX));
        b.b_top    = coord_t'($urandom_range(COORD_MAX - 300, COORD_MAX));
        b.b_width  = coord_t'($urandom_range(0, COORD_MAX));
        b.b_height = coord_t'($urandom_range(COORD_MAX - 300, COORD_MAX));
      end
    endcase
    return b;
  endfunction

  function automatic box_shape_e pick_shape();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 15) return SHAPE_NOISE;
    if (roll < 60) return SHAPE_OVERLAP;
    if (roll < 70) return SHAPE_ZERO_AREA;
    if (roll < 80) return SHAPE_NESTED;
    if (roll < 90) return SHAPE_TOUCHING;
    return SHAPE_FAR_EDGE;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_boxes(input box_pair_t b);
    if (src_idles && $urandom_range(0, 5) == 0) begin
      box_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    box_ch.a_left   = b.a_left;
    box_ch.a_top    = b.a_top;
    box_ch.a_width  = b.a_width;
    box_ch.a_height = b.a_height;
    box_ch.b_left   = b.b_left;
    box_ch.b_top    = b.b_top;
    box_ch.b_width  = b.b_width;
    box_ch.b_height = b.b_height;
    box_ch.valid    = 1'b1;
    do @(posedge clk); while (!box_ch.ready);
    pending_ious.push_back(predict_iou(b));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    box_ch.valid = 1'b0;
    while (pending_ious.size() != 0) @(negedge clk);
  endtask

  // receiver side: random stall bursts or a long counted hold
  initial begin
    iou_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        iou_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if (sink_idles && $urandom_range(0, 5) == 0) begin
        iou_ch.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      iou_ch.ready = 1'b1;
    end
  end

  initial begin
    iou_t got;
    iou_t want;
    forever begin
      @(posedge clk);
      if (rst_n && iou_ch.valid && iou_ch.ready) begin
        got.ratio       = iou_ch.ratio;
        got.union_empty = iou_ch.union_empty;
        if (pending_ious.size() == 0) begin
          $error("unexpected item: ratio %0d union_empty %0d", got.ratio, got.union_empty);
          mismatches++;
        end else begin
          want = pending_ious.pop_front();
          if (got.ratio !== want.ratio) begin
            $error("ratio: expected %0d, got %0d", want.ratio, got.ratio);
            mismatches++;
          end
          if (got.union_empty !== want.union_empty) begin
            $error("union_empty: expected %0d, got %0d", want.union_empty, got.union_empty);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    box_pair_t cases[$];
    cases.push_back(boxes(0, 0, 0, 0, 0, 0, 0, 0));
    cases.push_back(boxes(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    cases.push_back(boxes(0, 0, 4095, 4095, 0, 0, 4095, 4095));
    cases.push_back(boxes(10, 10, 0, 5, 100, 100, 7, 0));
    cases.push_back(boxes(0, 0, 100, 100, 50, 50, 0, 10));
    cases.push_back(boxes(0, 0, 10, 10, 20, 0, 10, 10));
    cases.push_back(boxes(0, 0, 10, 10, 0, 20, 10, 10));
    cases.push_back(boxes(0, 0, 10, 10, 10, 0, 10, 10));
    cases.push_back(boxes(0, 0, 10, 10, 10, 10, 5, 5));
    cases.push_back(boxes(0, 0, 100, 100, 25, 25, 50, 50));
    cases.push_back(boxes(0, 0, 10, 10, 5, 5, 10, 10));
    cases.push_back(boxes(4000, 4000, 4095, 4095, 4090, 4090, 4095, 4095));
    cases.push_back(boxes(7, 7, 1, 1, 7, 7, 1, 1));
    cases.push_back(boxes(0, 0, 4095, 4095, 0, 0, 4095, 4094));
    cases.push_back(boxes(300, 300, 0, 0, 300, 300, 0, 0));
    cases.push_back(boxes('hAAA, 'h555, 'hAAA, 'h555, 'h555, 'hAAA, 'h555, 'hAAA));
    cases.push_back(boxes(50, 50, 20, 20, 40, 45, 20, 20));
    foreach (cases[i]) send_boxes(cases[i]);
    wait_for_results();
  endtask

  task automatic test_random_boxes(input int count);
    src_idles  = 1'b1;
    sink_idles = 1'b1;
    repeat (count) send_boxes(random_boxes(pick_shape()));
    wait_for_results();
  endtask

  task automatic test_receiver_hold();
    src_idles   = 1'b0;
    sink_idles  = 1'b0;
    hold_cycles = 300;
    repeat (120) send_boxes(random_boxes(pick_shape()));
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    src_idles  = 1'b1;
    sink_idles = 1'b1;
    repeat (20) send_boxes(random_boxes(pick_shape()));
    wait_for_results();
    repeat (LATENCY) @(negedge clk);
    repeat (20) send_boxes(random_boxes(pick_shape()));
    wait_for_results();
  endtask

  task automatic test_full_rate(input int count);
    src_idles  = 1'b0;
    sink_idles = 1'b0;
    repeat (count) send_boxes(random_boxes(pick_shape()));
    wait_for_results();
  endtask

  initial begin
    rst_n           = 1'b0;
    box_ch.valid    = 1'b0;
    box_ch.a_left   = '0;
    box_ch.a_top    = '0;
    box_ch.a_width  = '0;
    box_ch.a_height = '0;
    box_ch.b_left   = '0;
    box_ch.b_top    = '0;
    box_ch.b_width  = '0;
    box_ch.b_height = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_boxes(900);
    test_receiver_hold();
    test_sender_pause();
    test_full_rate(280);

    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/iou_pkg.sv
hdl/iou_ifs.sv
hdl/iou_geom.sv
hdl/iou_div.sv
hdl/box_intersection_over_union.sv
tb/sv/box_intersection_over_union_test.sv
